[hw/rtl/binary_message_framer_fletcher_defines.svh]
// Assertion macros shared by the framer's RTL files.
`ifndef BINARY_MESSAGE_FRAMER_FLETCHER_DEFINES_SVH
`define BINARY_MESSAGE_FRAMER_FLETCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BMFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BMFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bmff_pkg.sv]
// Types and constants of the binary message framer.
package bmff_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h45;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h52;

  // One accepted item together with the checksums as they stand after it.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic        is_first;
    logic        is_last;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
  } bmff_entry_t;

  typedef struct packed {
    logic        push;
    bmff_entry_t entry;
  } bmff_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bmff_q_status_t;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_ID,
    PH_LENLO,
    PH_LENHI,
    PH_DATA,
    PH_CKA,
    PH_CKB
  } bmff_phase_e;

endpackage

[hw/rtl/bmff_front.sv]
// Input side: accepts items, keeps the running Fletcher sums and queues each item.
module bmff_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  logic [31:0]             s_tdata_i,  // payload_byte, msg_id, msg_length
  input  logic                    s_tlast_i,  // is_last
  input  logic                    s_tuser_i,  // is_first
  input  bmff_pkg::bmff_q_status_t q_status_i,
  output bmff_pkg::bmff_push_t     push_o
);
  import bmff_pkg::*;

  logic [7:0] sum_a_q, sum_a_d;
  logic [7:0] sum_b_q, sum_b_d;
  logic       accept;

  assign s_tready_o = !q_status_i.full;
  assign accept     = s_tvalid_i && s_tready_o;

  // The header bytes of a first item enter the sums ahead of its payload byte.
  always_comb begin
    logic [7:0] a0, b0, a1, b1, a2, b2, a3, b3;
    a0 = s_tuser_i ? 8'd0 : sum_a_q;
    b0 = s_tuser_i ? 8'd0 : sum_b_q;
    if (s_tuser_i) begin
      a1 = s_tdata_i[15:8];
      b1 = s_tdata_i[15:8];
      a2 = a1 + s_tdata_i[23:16];
      b2 = b1 + a2;
      a3 = a2 + s_tdata_i[31:24];
      b3 = b2 + a3;
    end else begin
      a3 = a0;
      b3 = b0;
      a1 = a0;
      b1 = b0;
      a2 = a0;
      b2 = b0;
    end
    sum_a_d = a3 + s_tdata_i[7:0];
    sum_b_d = b3 + sum_a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
    end else if (accept) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign push_o.push               = accept;
  assign push_o.entry.payload_byte = s_tdata_i[7:0];
  assign push_o.entry.msg_id       = s_tdata_i[15:8];
  assign push_o.entry.msg_length   = s_tdata_i[31:16];
  assign push_o.entry.is_first     = s_tuser_i;
  assign push_o.entry.is_last      = s_tlast_i;
  assign push_o.entry.sum_a        = sum_a_d;
  assign push_o.entry.sum_b        = sum_b_d;

endmodule

[hw/rtl/bmff_queue.sv]
// Short queue of classified items between the input side and the output sequencer.
`include "binary_message_framer_fletcher_defines.svh"

module bmff_queue #(
  parameter int unsigned DEPTH = bmff_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bmff_pkg::bmff_push_t     push_i,
  input  logic                     pop_i,
  output bmff_pkg::bmff_entry_t    head_o,
  output bmff_pkg::bmff_q_status_t status_o
);
  import bmff_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bmff_entry_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  `BMFF_ASSERT_IMP(a_no_push_full, push_i.push, !status_o.full, "push into full queue")
  `BMFF_ASSERT_IMP(a_no_pop_empty, pop_i, !status_o.empty, "pop from empty queue")
  `BMFF_ASSERT_NEXT(a_count_up, push_i.push && !pop_i, count_q == $past(count_q) + 1'b1,
                    "queue count did not follow a push")

endmodule

[hw/rtl/bmff_back.sv]
// Output sequencer: walks each queued item through header, payload and checksum bytes.
`include "binary_message_framer_fletcher_defines.svh"

module bmff_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bmff_pkg::bmff_entry_t    head_i,
  input  bmff_pkg::bmff_q_status_t q_status_i,
  output logic                     pop_o,
  input  logic [7:0]               sync_first_i,
  input  logic [7:0]               sync_second_i,
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [7:0]               m_tdata_o,  // out_byte
  output logic                     m_tlast_o,  // run_last
  output logic                     m_tuser_o   // frame_end
);
  import bmff_pkg::*;

  bmff_phase_e phase_q, phase_d, cur_phase;
  logic        start_q, start_d;
  logic        out_free, out_load;
  logic        m_valid_q;
  logic [7:0]  m_data_q, byte_d;
  logic        m_last_q, last_d;
  logic        m_user_q, user_d;
  logic        item_done;

  assign out_free = !m_valid_q || m_tready_i;
  assign out_load = out_free && !q_status_i.empty;

  // At the start of an item the phase comes from its kind, not from the register.
  assign cur_phase = start_q ? (head_i.is_first ? PH_SYNC1 : PH_DATA) : phase_q;

  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    item_done = 1'b0;
    byte_d    = head_i.payload_byte;
    last_d    = 1'b0;
    user_d    = 1'b0;
    case (cur_phase)
      PH_SYNC1: begin
        byte_d  = sync_first_i;
        phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        byte_d  = sync_second_i;
        phase_d = PH_ID;
      end
      PH_ID: begin
        byte_d  = head_i.msg_id;
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        byte_d  = head_i.msg_length[7:0];
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        byte_d  = head_i.msg_length[15:8];
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        byte_d    = head_i.payload_byte;
        last_d    = !head_i.is_last;
        item_done = !head_i.is_last;
        phase_d   = PH_CKA;
      end
      PH_CKA: begin
        byte_d  = head_i.sum_a;
        phase_d = PH_CKB;
      end
      PH_CKB: begin
        byte_d    = head_i.sum_b;
        last_d    = 1'b1;
        user_d    = 1'b1;
        item_done = 1'b1;
        phase_d   = PH_SYNC1;
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase
    if (!out_load) begin
      phase_d   = phase_q;
      item_done = 1'b0;
    end else begin
      start_d = item_done;
    end
  end

  assign pop_o = out_load && item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      start_q   <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      start_q <= start_d;
      if (out_free) begin
        m_valid_q <= !q_status_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= byte_d;
      m_last_q <= last_d;
      m_user_q <= user_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

  `BMFF_ASSERT_IMP(a_end_is_last, m_valid_q && m_user_q, m_last_q,
                   "frame end without run end")
  `BMFF_ASSERT_IMP(a_pop_at_end, pop_o,
                   cur_phase == PH_CKB || (cur_phase == PH_DATA && !head_i.is_last),
                   "item released before its last byte")
  `BMFF_ASSERT_NEXT(a_sync_order, out_load && cur_phase == PH_SYNC1,
                    phase_q == PH_SYNC2 && !start_q, "second sync byte does not follow first")

endmodule

[hw/rtl/binary_message_framer_fletcher.sv]
// Top level of the binary message framer with Fletcher-8 checksum.
//
//   channel  direction  handshake               payload
//   s_*      in         s_tvalid_i / s_tready_o tdata: byte, id, length; tlast: last; tuser: first
//   m_*      out        m_tvalid_o / m_tready_i tdata: out byte; tlast: run end; tuser: frame end
//   cfg_*    in         cfg_we_i                cfg_idx_i selects sync byte, cfg_data_i value
//
// A middle payload byte becomes one output byte, a first byte six, a last byte three
// and a one-byte message eight; the single output byte register sends them one by one.
// Input items enter the queue at one per cycle while it has room, so the input side
// runs ahead of the output by up to QUEUE_DEPTH items plus the output register.
// Reset empties the queue, clears the sums and loads the default sync bytes at once.
// A stall on the output holds its register and lets the queue fill behind it.
module binary_message_framer_fletcher #(
  parameter int unsigned QUEUE_DEPTH = bmff_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [31:0]                     s_tdata_i,  // payload_byte, msg_id, msg_length
  input  logic                            s_tlast_i,  // is_last
  input  logic                            s_tuser_i,  // is_first
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [7:0]                      m_tdata_o,  // out_byte
  output logic                            m_tlast_o,  // run_last
  output logic                            m_tuser_o,  // frame_end
  input  logic                            cfg_we_i,
  input  logic [bmff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmff_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmff_pkg::*;

  logic [7:0]     sync_first_q;
  logic [7:0]     sync_second_q;
  bmff_push_t     push;
  bmff_entry_t    head;
  bmff_q_status_t q_status;
  logic           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i[7:0];
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  bmff_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .s_tuser_i  (s_tuser_i),
    .q_status_i (q_status),
    .push_o     (push)
  );

  bmff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  bmff_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_o     (m_tdata_o),
    .m_tlast_o     (m_tlast_o),
    .m_tuser_o     (m_tuser_o)
  );

endmodule

[tb/sv/tb_binary_message_framer_fletcher.sv]
// Testbench for the binary message framer: random stream traffic checked against a frame predictor.
`timescale 1ns / 100ps

module tb_binary_message_framer_fletcher;
  import bmff_pkg::*;

  localparam int unsigned IDLE_PCT       = 34;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic        is_first;
    logic        is_last;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  // Predicts the framed byte stream and checks the block's output against it.
  class framer_checker;
    logic [7:0]   sync_first;
    logic [7:0]   sync_second;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    framed_byte_t expected_bytes[$];
    int unsigned  errors;

    function new();
      sync_first  = SYNC_FIRST_RST;
      sync_second = SYNC_SECOND_RST;
      sum_a       = 8'h00;
      sum_b       = 8'h00;
      errors      = 0;
    endfunction

    function void set_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
      if (idx == REG_SYNC_FIRST) begin
        sync_first = value;
      end else if (idx == REG_SYNC_SECOND) begin
        sync_second = value;
      end
    endfunction

    function void add_to_sums(input logic [7:0] value);
      sum_a = sum_a + value;
      sum_b = sum_b + sum_a;
    endfunction

    function void frame_item(input framer_item_t it);
      framed_byte_t run[$];
      framed_byte_t fb;
      if (it.is_first) begin
        sum_a = 8'h00;
        sum_b = 8'h00;
        run.push_back('{sync_first, 1'b0, 1'b0});
        run.push_back('{sync_second, 1'b0, 1'b0});
        run.push_back('{it.msg_id, 1'b0, 1'b0});
        add_to_sums(it.msg_id);
        run.push_back('{it.msg_length[7:0], 1'b0, 1'b0});
        add_to_sums(it.msg_length[7:0]);
        run.push_back('{it.msg_length[15:8], 1'b0, 1'b0});
        add_to_sums(it.msg_length[15:8]);
      end
      run.push_back('{it.payload_byte, 1'b0, 1'b0});
      add_to_sums(it.payload_byte);
      if (it.is_last) begin
        run.push_back('{sum_a, 1'b0, 1'b0});
        run.push_back('{sum_b, 1'b0, 1'b1});
      end
      // Only the final byte of each item's run carries tlast.
      fb = run.pop_back();
      fb.run_last = 1'b1;
      run.push_back(fb);
      foreach (run[k]) expected_bytes.push_back(run[k]);
    endfunction

    function void check_frame_byte(input logic [7:0] data, input logic last, input logic user);
      framed_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: actual data %02h last %0b user %0b",
                 $time, data, last, user);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (data !== exp_b.out_byte) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %02h actual %02h",
                   $time, exp_b.out_byte, data);
        end
        if (last !== exp_b.run_last) begin
          errors++;
          $display("%0t: run_last mismatch: expected %0b actual %0b",
                   $time, exp_b.run_last, last);
        end
        if (user !== exp_b.frame_end) begin
          errors++;
          $display("%0t: frame_end mismatch: expected %0b actual %0b",
                   $time, exp_b.frame_end, user);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [31:0]           s_tdata_i;  // payload_byte, msg_id, msg_length
  logic                  s_tlast_i;  // is_last
  logic                  s_tuser_i;  // is_first
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [7:0]            m_tdata_o;  // out_byte
  logic                  m_tlast_o;  // run_last
  logic                  m_tuser_o;  // frame_end
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  framer_checker frame_chk;
  bit            tx_steady;
  bit            rx_steady;
  bit            hold_pending;
  int unsigned   quiet_cycles = 0;

  binary_message_framer_fletcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic framer_item_t make_item(input logic [7:0] data, input logic [7:0] id,
                                             input logic [15:0] len, input logic first,
                                             input logic last);
    framer_item_t it;
    it.payload_byte = data;
    it.msg_id       = id;
    it.msg_length   = len;
    it.is_first     = first;
    it.is_last      = last;
    return it;
  endfunction

  task automatic send_item(input framer_item_t it);
    @(negedge clk_i);
    while (!tx_steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {it.msg_length, it.msg_id, it.payload_byte};
    s_tlast_i  <= it.is_last;
    s_tuser_i  <= it.is_first;
    do @(posedge clk_i); while (!s_tready_o);
    frame_chk.frame_item(it);
  endtask

  // One message of nbytes payload bytes; the length field may disagree with nbytes.
  task automatic send_message(input int unsigned nbytes, input bit len_matches);
    logic [7:0]  id;
    logic [15:0] len;
    id  = 8'($urandom_range(0, 255));
    len = len_matches ? 16'(nbytes) : 16'($urandom_range(1, 65535));
    for (int unsigned k = 0; k < nbytes; k++) begin
      send_item(make_item(8'($urandom_range(0, 255)),
                          (k == 0) ? id : 8'($urandom_range(0, 255)),
                          (k == 0) ? len : 16'($urandom_range(0, 65535)),
                          k == 0, k == nbytes - 1));
    end
  endtask

  task automatic send_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned nbytes;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        send_message(nbytes, $urandom_range(0, 3) != 0);
        sent += nbytes;
      end else begin
        // Stray bytes with arbitrary flags: orphans, restarts and lone trailers.
        send_item(make_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (frame_chk.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync_pair(input logic [7:0] first_val, input logic [7:0] second_val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SYNC_FIRST;
    cfg_data_i <= first_val;
    @(negedge clk_i);
    cfg_idx_i  <= REG_SYNC_SECOND;
    cfg_data_i <= second_val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    frame_chk.set_sync(REG_SYNC_FIRST, first_val);
    frame_chk.set_sync(REG_SYNC_SECOND, second_val);
  endtask

  // Output ready; a requested hold-off keeps it low while the input side fills up.
  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_tready_i <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      frame_chk.check_frame_byte(m_tdata_o, m_tlast_o, m_tuser_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_binary_message_framer_fletcher: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    frame_chk    = new();
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tlast_i    = 1'b0;
    s_tuser_i    = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_SYNC_FIRST;
    cfg_data_i   = '0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_pending = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the sync bytes left at their reset values.
    send_item(make_item(8'h00, 8'h00, 16'h0000, 1'b1, 1'b1));  // one-byte, zero length
    send_item(make_item(8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
    send_item(make_item(8'h01, 8'h5A, 16'h0003, 1'b1, 1'b0));
    send_item(make_item(8'h80, 8'hA5, 16'h1234, 1'b0, 1'b0));
    send_item(make_item(8'hFE, 8'h00, 16'h0000, 1'b0, 1'b1));
    // Bytes after a finished frame keep adding to the retained sums.
    send_item(make_item(8'h33, 8'hC0, 16'hBEEF, 1'b0, 1'b0));
    send_item(make_item(8'h7F, 8'h0C, 16'h4321, 1'b0, 1'b1));
    // A new start before the open message ends drops the old trailer.
    send_item(make_item(8'h10, 8'h11, 16'h0005, 1'b1, 1'b0));
    send_item(make_item(8'h20, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_item(make_item(8'h30, 8'h22, 16'h0002, 1'b1, 1'b0));
    send_item(make_item(8'h40, 8'h00, 16'h0000, 1'b0, 1'b1));
    // Declared lengths that disagree with the bytes sent.
    send_item(make_item(8'h55, 8'h66, 16'h0001, 1'b1, 1'b0));
    send_item(make_item(8'hAA, 8'h99, 16'h00FF, 1'b0, 1'b0));
    send_item(make_item(8'hC3, 8'h3C, 16'hFF00, 1'b0, 1'b1));
    send_item(make_item(8'h0F, 8'h77, 16'h8001, 1'b1, 1'b1));
    wait_drained();

    write_sync_pair(8'h00, 8'hFF);
    send_traffic(170);
    wait_drained();

    // Both sides steady, with one long output stall so the input backs up.
    write_sync_pair(8'hFF, 8'h00);
    tx_steady    = 1'b1;
    rx_steady    = 1'b1;
    hold_pending = 1'b1;
    send_traffic(120);
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    write_sync_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_traffic(200);
    wait_drained();

    if (frame_chk.errors == 0 && frame_chk.pending() == 0) begin
      $display("tb_binary_message_framer_fletcher: done, clean");
    end else begin
      $display("tb_binary_message_framer_fletcher: done, errors");
    end
    $finish;
  end

endmodule
